/* rtl/bmssr_pkg.sv */
// Shared types and constants for the bidirectional motor soft-start ramp block.
package bmssr_pkg;

    localparam int PWM_W  = 10;
    localparam int TIME_W = 16;
    localparam int NOW_W  = 32;

    // Restoring divider: dividend is |range| * elapsed
    localparam int DIV_W     = PWM_W + TIME_W;
    localparam int DIV_STEPS = DIV_W;

    localparam logic [TIME_W-1:0] ACCEL_RST  = 16'd600;
    localparam logic [TIME_W-1:0] DECEL_RST  = 16'd600;
    localparam logic [PWM_W-1:0]  MAX_RST    = 10'd950;
    localparam logic [PWM_W-1:0]  MIN_RST    = 10'd15;
    localparam logic [TIME_W-1:0] SETTLE_RST = 16'd20;
    localparam logic [PWM_W-1:0]  SAMPLE_IDLE = 10'd500;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd4;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ESTOP = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_STOPPED   = 3'd0,
        ST_STOPPING  = 3'd1,
        ST_START_FWD = 3'd2,
        ST_RUN_FWD   = 3'd3,
        ST_START_REV = 3'd4,
        ST_RUN_REV   = 3'd5,
        ST_FAULT     = 3'd6
    } t_mode;

    typedef struct packed {
        t_op               op;
        logic [NOW_W-1:0]  now_ms;
        logic              fwd_request;
        logic              rev_request;
        logic              fwd_limit;
        logic              rev_limit;
    } t_item;

    typedef struct packed {
        t_mode             motor_state;
        logic [PWM_W-1:0]  pwm_level;
        logic [PWM_W-1:0]  fwd_duty;
        logic [PWM_W-1:0]  rev_duty;
        logic [PWM_W-1:0]  sample_compare;
        logic [1:0]        drive_direction;
        logic              brake_engaged;
    } t_result;

    typedef struct packed {
        logic load;
        logic update;
        logic mul;
        logic div_step;
        logic finish;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
    } t_dp_stat;

endpackage

/* rtl/bmssr_dp.sv */
// Datapath: motor state registers, next-state logic, ramp multiplier and serial divider.
module bmssr_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bmssr_pkg::t_dp_cmd                i_cmd,
    output bmssr_pkg::t_dp_stat               o_stat,
    input  bmssr_pkg::t_item                  i_item,
    input  logic                              i_cfg_we,
    input  logic [bmssr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bmssr_pkg::TIME_W-1:0]      i_cfg_data,
    output bmssr_pkg::t_result                o_result
);
    import bmssr_pkg::*;

    // configuration
    logic [TIME_W-1:0] r_accel, r_decel, r_settle;
    logic [PWM_W-1:0]  r_max, r_min;

    // architectural state
    t_mode             r_mode, r_before;
    logic [NOW_W-1:0]  r_stamp;
    logic [PWM_W-1:0]  r_pwm, r_goal;
    logic              r_estop, r_brake;
    logic [1:0]        r_dir;

    t_item             r_item;

    // ramp operands and divider
    logic [PWM_W-1:0]  r_from, r_mag;
    logic              r_neg;
    logic [TIME_W-1:0] r_elap, r_span;
    logic [DIV_W-1:0]  r_quo;
    logic [TIME_W-1:0] r_rem;
    t_result           r_res;

    t_mode             n_mode, n_before, next_mode;
    logic [NOW_W-1:0]  n_stamp;
    logic [PWM_W-1:0]  n_pwm, n_goal;
    logic              n_estop, n_brake, entered, ramp_sel;
    logic [1:0]        n_dir;
    logic [NOW_W-1:0]  elapsed_old, elapsed_new;

    logic [TIME_W-1:0] span;
    logic [PWM_W-1:0]  ramp_from, ramp_to, mag;
    logic              ramp_done;

    logic [TIME_W:0]   rem_sh;
    logic [TIME_W+1:0] rem_diff;
    logic              q_bit;
    logic [PWM_W-1:0]  fd, rd;

    assign elapsed_old = r_item.now_ms - r_stamp;

    always_comb begin
        n_mode    = r_mode;
        n_before  = r_before;
        n_stamp   = r_stamp;
        n_pwm     = r_pwm;
        n_goal    = r_goal;
        n_estop   = r_estop;
        n_dir     = r_dir;
        n_brake   = r_brake;
        next_mode = r_mode;
        entered   = 1'b0;
        ramp_sel  = 1'b0;
        unique case (r_item.op)
            OP_TICK: begin
                if (r_estop) begin
                    if (r_mode != ST_STOPPED && r_mode != ST_FAULT) begin
                        n_before = r_mode;
                        n_mode   = ST_STOPPED;
                        n_stamp  = r_item.now_ms;
                        n_pwm    = '0;
                        n_brake  = 1'b1;
                    end
                end else if (r_item.fwd_request && r_item.rev_request) begin
                    n_mode  = ST_FAULT;
                    n_stamp = r_item.now_ms;
                    n_pwm   = '0;
                    n_brake = 1'b1;
                end else begin
                    unique case (r_mode)
                        ST_STOPPED: begin
                            if (elapsed_old >= {{(NOW_W-TIME_W){1'b0}}, r_settle}) begin
                                if (r_item.fwd_request && !r_item.fwd_limit) begin
                                    next_mode = ST_START_FWD;
                                end else if (r_item.rev_request && !r_item.rev_limit) begin
                                    next_mode = ST_START_REV;
                                end
                            end
                        end
                        ST_START_FWD: begin
                            if (r_item.fwd_limit || !r_item.fwd_request) begin
                                next_mode = ST_STOPPING;
                            end else if (elapsed_old >= {{(NOW_W-TIME_W){1'b0}}, r_accel}) begin
                                next_mode = ST_RUN_FWD;
                            end
                        end
                        ST_RUN_FWD: begin
                            if (r_item.fwd_limit || !r_item.fwd_request) begin
                                next_mode = ST_STOPPING;
                            end
                        end
                        ST_START_REV: begin
                            if (r_item.rev_limit || !r_item.rev_request) begin
                                next_mode = ST_STOPPING;
                            end else if (elapsed_old >= {{(NOW_W-TIME_W){1'b0}}, r_accel}) begin
                                next_mode = ST_RUN_REV;
                            end
                        end
                        ST_RUN_REV: begin
                            if (r_item.rev_limit || !r_item.rev_request) begin
                                next_mode = ST_STOPPING;
                            end
                        end
                        ST_STOPPING: begin
                            if (r_pwm <= r_min) begin
                                next_mode = ST_STOPPED;
                            end
                        end
                        ST_FAULT: ;
                        default: ;
                    endcase
                    if (next_mode != r_mode) begin
                        entered  = 1'b1;
                        n_before = r_mode;
                        n_mode   = next_mode;
                        n_stamp  = r_item.now_ms;
                        unique case (next_mode)
                            ST_STOPPED: begin
                                n_goal  = '0;
                                n_brake = 1'b1;
                                n_dir   = DIR_STOP;
                            end
                            ST_START_FWD: begin
                                n_dir   = DIR_FWD;
                                n_brake = 1'b0;
                                n_goal  = r_max;
                            end
                            ST_START_REV: begin
                                n_dir   = DIR_REV;
                                n_brake = 1'b0;
                                n_goal  = r_max;
                            end
                            ST_RUN_FWD, ST_RUN_REV: n_goal = r_max;
                            ST_STOPPING: n_goal = '0;
                            default: ;
                        endcase
                    end
                    if (n_mode == ST_START_FWD || n_mode == ST_START_REV
                        || n_mode == ST_STOPPING) begin
                        ramp_sel = 1'b1;
                    end else if (n_mode == ST_RUN_FWD || n_mode == ST_RUN_REV) begin
                        n_pwm = n_goal;
                    end
                end
            end
            OP_ESTOP: begin
                n_estop = 1'b1;
                n_goal  = '0;
                n_brake = 1'b1;
            end
            OP_CLEAR: begin
                if (r_mode == ST_FAULT) begin
                    n_mode  = ST_STOPPED;
                    n_estop = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // ramp endpoints for the mode after this tick; a fresh entry has zero elapsed time
    assign elapsed_new = entered ? '0 : elapsed_old;

    always_comb begin
        if (n_mode == ST_STOPPING) begin
            span      = r_decel;
            ramp_from = (n_before == ST_RUN_FWD || n_before == ST_RUN_REV) ? r_max : r_pwm;
            ramp_to   = r_min;
        end else begin
            span      = r_accel;
            ramp_from = r_min;
            ramp_to   = r_max;
        end
        ramp_done = elapsed_new >= {{(NOW_W-TIME_W){1'b0}}, span};
        mag       = (ramp_to >= ramp_from) ? ramp_to - ramp_from : ramp_from - ramp_to;
    end

    assign o_stat.need_div = ramp_sel && !ramp_done;

    // one restoring division step
    assign rem_sh   = {r_rem, r_quo[DIV_W-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, r_span};
    assign q_bit    = !rem_diff[TIME_W+1];

    // duty selection from the committed state
    always_comb begin
        fd = '0;
        rd = '0;
        if (!r_estop && r_mode != ST_FAULT) begin
            if (r_mode == ST_START_FWD || r_mode == ST_RUN_FWD) begin
                fd = r_pwm;
            end else if (r_mode == ST_START_REV || r_mode == ST_RUN_REV) begin
                rd = r_pwm;
            end else if (r_mode == ST_STOPPING) begin
                if (r_before == ST_START_FWD || r_before == ST_RUN_FWD) begin
                    fd = r_pwm;
                end else if (r_before == ST_START_REV || r_before == ST_RUN_REV) begin
                    rd = r_pwm;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel  <= ACCEL_RST;
            r_decel  <= DECEL_RST;
            r_max    <= MAX_RST;
            r_min    <= MIN_RST;
            r_settle <= SETTLE_RST;
            r_mode   <= ST_STOPPED;
            r_before <= ST_STOPPED;
            r_stamp  <= '0;
            r_pwm    <= '0;
            r_goal   <= '0;
            r_estop  <= 1'b0;
            r_dir    <= DIR_STOP;
            r_brake  <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ACCEL:  r_accel  <= i_cfg_data;
                    CFG_DECEL:  r_decel  <= i_cfg_data;
                    CFG_MAX:    r_max    <= i_cfg_data[PWM_W-1:0];
                    CFG_MIN:    r_min    <= i_cfg_data[PWM_W-1:0];
                    CFG_SETTLE: r_settle <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.update) begin
                r_mode   <= n_mode;
                r_before <= n_before;
                r_stamp  <= n_stamp;
                r_goal   <= n_goal;
                r_estop  <= n_estop;
                r_dir    <= n_dir;
                r_brake  <= n_brake;
                if (!ramp_sel) begin
                    r_pwm <= n_pwm;
                end else if (ramp_done) begin
                    r_pwm <= ramp_to;
                end
            end
            if (i_cmd.finish) begin
                r_pwm <= r_neg ? r_from - r_quo[PWM_W-1:0] : r_from + r_quo[PWM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.update) begin
            r_from <= ramp_from;
            r_mag  <= mag;
            r_neg  <= ramp_to < ramp_from;
            r_elap <= elapsed_new[TIME_W-1:0];
            r_span <= span;
        end
        if (i_cmd.mul) begin
            r_quo <= {{TIME_W{1'b0}}, r_mag} * {{PWM_W{1'b0}}, r_elap};
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[DIV_W-2:0], q_bit};
            r_rem <= q_bit ? rem_diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
        end
        if (i_cmd.capture) begin
            r_res.motor_state     <= r_mode;
            r_res.pwm_level       <= r_pwm;
            r_res.fwd_duty        <= fd;
            r_res.rev_duty        <= rd;
            r_res.sample_compare  <= (r_pwm == '0) ? SAMPLE_IDLE : r_pwm;
            r_res.drive_direction <= r_dir;
            r_res.brake_engaged   <= r_brake;
        end
    end

    assign o_result = r_res;

endmodule

/* rtl/bmssr_ctrl.sv */
// Controller: sequences update, multiply, divide steps and result capture for each item.
module bmssr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output bmssr_pkg::t_dp_cmd    o_cmd,
    input  bmssr_pkg::t_dp_stat   i_stat
);
    import bmssr_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_MUL,
        S_DIV,
        S_FINISH,
        S_CAPTURE
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.update   = (r_state == S_UPDATE);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.finish   = (r_state == S_FINISH);
        o_cmd.capture  = (r_state == S_CAPTURE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a capture in the same cycle keeps the output valid
            if (r_out_valid && i_out_ready && !o_cmd.capture) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_state <= i_stat.need_div ? S_MUL : S_CAPTURE;
                end
                S_MUL: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_state <= S_CAPTURE;
                end
                S_CAPTURE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/bidirectional_motor_soft_start_ramp.sv */
// Top level of the bidirectional motor soft-start / soft-stop ramp controller.
// Each input transaction carries a command in tuser (tick, emergency stop, clear fault) and
// the millisecond timestamp, direction requests and limit switches in tdata; each produces
// one output transaction with state, ramped PWM, both channel duties, the sample compare,
// direction and brake. Items are processed one at a time. An item that needs no ramp
// interpolation goes through update and capture before the next is accepted; a tick inside
// an acceleration or deceleration ramp adds multiply, the 26-step restoring divider that
// interpolates the PWM level, and finish. The finished result waits in an output register,
// so a stalled output only blocks once a second result is ready. Configuration writes are
// accepted every cycle and must only be issued while the block is idle.
module bidirectional_motor_soft_start_ramp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] now_ms, [32] fwd_request, [33] rev_request, [34] fwd_limit, [35] rev_limit
    input  logic [39:0] i_s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] motor_state, [12:3] pwm_level, [22:13] fwd_duty, [32:23] rev_duty,
    // [42:33] sample_compare, [44:43] drive_direction, [45] brake_engaged
    output logic [47:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import bmssr_pkg::*;

    t_item    item;
    t_result  res;
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign item.op          = t_op'(i_s_axis_tuser);
    assign item.now_ms      = i_s_axis_tdata[31:0];
    assign item.fwd_request = i_s_axis_tdata[32];
    assign item.rev_request = i_s_axis_tdata[33];
    assign item.fwd_limit   = i_s_axis_tdata[34];
    assign item.rev_limit   = i_s_axis_tdata[35];

    assign o_cfg_ready = 1'b1;

    bmssr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    bmssr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_item      (item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (res)
    );

    assign o_m_axis_tdata = {2'b00,
                             res.brake_engaged,
                             res.drive_direction,
                             res.sample_compare,
                             res.rev_duty,
                             res.fwd_duty,
                             res.pwm_level,
                             res.motor_state};

endmodule
